### hw/rtl/hfc_pkg.sv
// -----------------------------------------------------------------------------
// hfc_pkg
// Shared types and codes of the humidity fan controller.
// -----------------------------------------------------------------------------
package hfc_pkg;

    // Item field widths
    localparam int MODE_W     = 3;
    localparam int HUM_W      = 8;
    localparam int LEVEL_W    = 7;
    localparam int COUNT_W    = 16;
    localparam int FSTATE_W   = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_TIMEOUT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_DELTA     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ABSOLUTE_LIMIT = 2'd3;

    localparam logic [COUNT_W-1:0] CHECK_INTERVAL_RST = 16'd60;
    localparam logic [COUNT_W-1:0] RUN_TIMEOUT_RST    = 16'd600;
    localparam logic [LEVEL_W-1:0] RISE_DELTA_RST     = 7'd5;
    localparam logic [LEVEL_W-1:0] ABSOLUTE_LIMIT_RST = 7'd80;

    localparam int HISTORY_DEPTH_DEF = 8;

    // Item kinds
    localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_AUTO   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BUTTON = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TRIG   = 3'd4;

    // Fan states as reported
    localparam logic [FSTATE_W-1:0] FAN_WAIT     = 2'd0;
    localparam logic [FSTATE_W-1:0] FAN_REQ      = 2'd1;
    localparam logic [FSTATE_W-1:0] FAN_RUN_AUTO = 2'd2;
    localparam logic [FSTATE_W-1:0] FAN_RUN_MAN  = 2'd3;

    typedef struct packed {
        logic                auto_on;
        logic [FSTATE_W-1:0] fan_state;
        logic                relay_on;
        logic                relay_changed;
        logic                state_report;
        logic                humidity_request;
        logic [LEVEL_W-1:0]  normal_level;
        logic [LEVEL_W-1:0]  average_level;
        logic [COUNT_W-1:0]  time_left;
    } result_t;

    function automatic logic fan_running(input logic [FSTATE_W-1:0] s);
        return (s == FAN_RUN_AUTO) || (s == FAN_RUN_MAN);
    endfunction

endpackage

### hw/rtl/hfc_if.sv
// -----------------------------------------------------------------------------
// hfc_if
// Valid/ready channels of the humidity fan controller.
// -----------------------------------------------------------------------------
interface hfc_item_if
    import hfc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [HUM_W-1:0]  humidity;
    logic                     switch_on;

    modport source (output valid, output mode, output humidity, output switch_on,
                    input ready);
    modport sink   (input valid, input mode, input humidity, input switch_on,
                    output ready);
endinterface

interface hfc_result_if
    import hfc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                auto_on;
    logic [FSTATE_W-1:0] fan_state;
    logic                relay_on;
    logic                relay_changed;
    logic                state_report;
    logic                humidity_request;
    logic [LEVEL_W-1:0]  normal_level;
    logic [LEVEL_W-1:0]  average_level;
    logic [COUNT_W-1:0]  time_left;

    modport source (output valid, output auto_on, output fan_state, output relay_on,
                    output relay_changed, output state_report,
                    output humidity_request, output normal_level,
                    output average_level, output time_left, input ready);
    modport sink   (input valid, input auto_on, input fan_state, input relay_on,
                    input relay_changed, input state_report,
                    input humidity_request, input normal_level,
                    input average_level, input time_left, output ready);
endinterface

### hw/rtl/humidity_fan_controller_top.sv
// -----------------------------------------------------------------------------
// humidity_fan_controller_top
// Humidity driven fan relay controller with a serial history averager.
// -----------------------------------------------------------------------------
//  channel     dir  handshake      contents
//  item_in     in   valid/ready    mode, humidity, switch_on
//  result_out  out  valid/ready    relay level and change, state, status
//  cfg         in   cfg_we only    cfg_index selects register, cfg_data value
//
//  Most items pass decode and state update, then hand-off to the result
//  register. A tick that hits the check interval runs the averager in
//  between: the history ring is scanned one entry a cycle, then a
//  restoring divider makes one quotient bit a cycle. Reset clears all
//  state but the result payload registers and loads register defaults;
//  no clearing pass. One item is taken while a result waits in the output
//  register; the next one waits until that result moves on.
// -----------------------------------------------------------------------------
module humidity_fan_controller_top
    import hfc_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    hfc_item_if.sink              item_in,
    hfc_result_if.source          result_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Sum of up to HISTORY_DEPTH positive 7-bit samples
    localparam int SUM_W   = $clog2(HISTORY_DEPTH * 127 + 1);
    localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int IDX_W   = $clog2(HISTORY_DEPTH);
    localparam int DSTEP_W = $clog2(SUM_W);

    typedef enum logic [3:0] {
        SEQ_IDLE = 4'b0001,
        SEQ_SUM  = 4'b0010,
        SEQ_DIV  = 4'b0100,
        SEQ_OUT  = 4'b1000
    } seq_t;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_RISE,
        EV_MAXABS,
        EV_NORMAL,
        EV_TRIG_ON,
        EV_TRIG_OFF,
        EV_TIMER,
        EV_BUTTON
    } fan_ev_t;

    // Configuration
    logic [COUNT_W-1:0] check_interval_reg;
    logic [COUNT_W-1:0] run_timeout_reg;
    logic [LEVEL_W-1:0] rise_delta_reg;
    logic [LEVEL_W-1:0] absolute_limit_reg;

    // Controller state
    logic                auto_reg,  auto_next;
    logic [FSTATE_W-1:0] state_reg, state_next;
    logic [LEVEL_W-1:0]  base_reg,  base_next;
    logic [LEVEL_W-1:0]  avg_reg,   avg_next;
    logic [COUNT_W-1:0]  chk_reg,   chk_next;
    logic [COUNT_W-1:0]  run_reg,   run_next;
    logic [HUM_W-1:0]    hist_reg [HISTORY_DEPTH];

    // Averager
    seq_t                seq_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [DSTEP_W-1:0]  dstep_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    rem_reg;

    // Result staging
    result_t             pend_reg;
    result_t             out_reg;
    logic                out_valid_reg;

    // Item decode
    logic                accept;
    logic                report, request, fire, hist_clear, sample_write, changed;
    fan_ev_t             ev;
    logic [COUNT_W-1:0]  chk_inc, run_inc, time_left;
    logic [HUM_W-1:0]    hum;
    logic                hum_pos, avg_pos;
    logic [LEVEL_W:0]    rise_level;
    logic                hum_at_limit;

    // Averager datapath
    logic [HUM_W-1:0]    tap, oldest;
    logic                tap_pos, oldest_pos, head_pos;
    logic [CNT_W:0]      trial;
    logic                qbit;
    logic [SUM_W-1:0]    quo_next;
    logic                out_free;

    assign accept   = item_in.valid && item_in.ready;
    assign out_free = !out_valid_reg || result_out.ready;
    assign item_in.ready = (seq_reg == SEQ_IDLE);

    assign hum          = item_in.humidity;
    assign hum_pos      = !hum[HUM_W-1] && (hum != '0);
    assign avg_pos      = (avg_reg != '0);
    assign rise_level   = {1'b0, avg_reg} + {1'b0, rise_delta_reg};
    assign hum_at_limit = !hum[HUM_W-1] && (hum[LEVEL_W-1:0] >= absolute_limit_reg);

    assign chk_inc = chk_reg + COUNT_W'(1);
    assign run_inc = run_reg + COUNT_W'(1);

    // Item decode and fan state machine, evaluated at acceptance
    always_comb
    begin
        auto_next    = auto_reg;
        state_next   = state_reg;
        base_next    = base_reg;
        avg_next     = avg_reg;
        chk_next     = chk_reg;
        run_next     = run_reg;
        report       = 1'b0;
        request      = 1'b0;
        fire         = 1'b0;
        hist_clear   = 1'b0;
        sample_write = 1'b0;
        ev           = EV_NONE;

        unique case (item_in.mode)
            MODE_TICK:
            begin
                if (auto_reg)
                begin
                    chk_next = chk_inc;
                    if (chk_inc >= check_interval_reg)
                    begin
                        chk_next = '0;
                        fire     = 1'b1;
                        request  = 1'b1;
                    end
                end
                if (fan_running(state_reg))
                begin
                    run_next = run_inc;
                    if (run_inc > run_timeout_reg)
                        ev = EV_TIMER;
                end
            end
            MODE_SAMPLE:
            begin
                if (auto_reg)
                begin
                    sample_write = 1'b1;
                    if (hum_pos && avg_pos && ({1'b0, hum[LEVEL_W-1:0]} >= rise_level))
                        ev = EV_RISE;
                    else if (hum_pos && avg_pos && (base_reg >= hum[LEVEL_W-1:0]))
                        ev = EV_NORMAL;
                    else if (hum_at_limit)
                        ev = EV_MAXABS;
                end
            end
            MODE_AUTO:
            begin
                report = 1'b1;
                if (item_in.switch_on)
                begin
                    if (!auto_reg)
                    begin
                        auto_next  = 1'b1;
                        hist_clear = 1'b1;
                        avg_next   = '0;
                        base_next  = '0;
                        chk_next   = '0;
                    end
                end
                else if (auto_reg)
                begin
                    auto_next = 1'b0;
                    if (state_reg == FAN_REQ || state_reg == FAN_RUN_AUTO)
                    begin
                        base_next  = '0;
                        state_next = FAN_WAIT;
                    end
                end
            end
            MODE_BUTTON:
                ev = EV_BUTTON;
            MODE_TRIG:
            begin
                if (auto_reg)
                    ev = item_in.switch_on ? EV_TRIG_ON : EV_TRIG_OFF;
            end
            default:
                ;
        endcase

        unique case (ev)
            EV_BUTTON:
            begin
                base_next = '0;
                if (state_reg == FAN_WAIT || state_reg == FAN_REQ)
                begin
                    run_next   = '0;
                    state_next = FAN_RUN_MAN;
                end
                else
                    state_next = FAN_WAIT;
            end
            EV_RISE:
            begin
                if (state_reg == FAN_WAIT)
                begin
                    base_next  = avg_reg;
                    state_next = FAN_REQ;
                end
            end
            EV_MAXABS:
            begin
                if (state_reg == FAN_WAIT)
                begin
                    base_next  = '0;
                    state_next = FAN_REQ;
                end
            end
            EV_NORMAL:
            begin
                if (state_reg == FAN_REQ || state_reg == FAN_RUN_AUTO)
                begin
                    base_next  = '0;
                    state_next = FAN_WAIT;
                end
            end
            EV_TRIG_OFF:
            begin
                if (state_reg == FAN_RUN_AUTO)
                    state_next = FAN_REQ;
            end
            EV_TRIG_ON:
            begin
                if (state_reg == FAN_REQ)
                begin
                    run_next   = '0;
                    state_next = FAN_RUN_AUTO;
                end
            end
            EV_TIMER:
            begin
                if (state_reg != FAN_WAIT)
                begin
                    base_next  = '0;
                    state_next = FAN_WAIT;
                end
            end
            default:
                ;
        endcase

        changed = fan_running(state_reg) != fan_running(state_next);
        if (state_next != state_reg)
            report = 1'b1;
    end

    assign time_left = (run_timeout_reg > run_next) ? (run_timeout_reg - run_next) : '0;

    // Averager datapath: ring tap and one restoring divide step
    assign tap        = hist_reg[HISTORY_DEPTH-1];
    assign tap_pos    = !tap[HUM_W-1] && (tap != '0);
    assign oldest     = hist_reg[HISTORY_DEPTH-1];
    assign oldest_pos = !oldest[HUM_W-1] && (oldest != '0);
    assign head_pos   = !hist_reg[0][HUM_W-1] && (hist_reg[0] != '0);
    assign trial      = {rem_reg, sum_reg[SUM_W-1]};
    assign qbit       = (trial >= {1'b0, cnt_reg});
    assign quo_next   = {sum_reg[SUM_W-2:0], qbit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_interval_reg <= CHECK_INTERVAL_RST;
            run_timeout_reg    <= RUN_TIMEOUT_RST;
            rise_delta_reg     <= RISE_DELTA_RST;
            absolute_limit_reg <= ABSOLUTE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHECK_INTERVAL: check_interval_reg <= cfg_data;
                CFG_RUN_TIMEOUT:    run_timeout_reg    <= cfg_data;
                CFG_RISE_DELTA:     rise_delta_reg     <= cfg_data[LEVEL_W-1:0];
                CFG_ABSOLUTE_LIMIT: absolute_limit_reg <= cfg_data[LEVEL_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_reg      <= 1'b0;
            state_reg     <= FAN_WAIT;
            base_reg      <= '0;
            avg_reg       <= '0;
            chk_reg       <= '0;
            run_reg       <= '0;
            seq_reg       <= SEQ_IDLE;
            idx_reg       <= '0;
            dstep_reg     <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
                hist_reg[i] <= '0;
        end
        else
        begin
            if (out_valid_reg && result_out.ready)
                out_valid_reg <= 1'b0;

            unique case (seq_reg)
                SEQ_IDLE:
                begin
                    if (accept)
                    begin
                        auto_reg  <= auto_next;
                        state_reg <= state_next;
                        base_reg  <= base_next;
                        avg_reg   <= avg_next;
                        chk_reg   <= chk_next;
                        run_reg   <= run_next;
                        if (hist_clear)
                        begin
                            for (int i = 0; i < HISTORY_DEPTH; i++)
                                hist_reg[i] <= '0;
                        end
                        else if (sample_write)
                            hist_reg[0] <= hum;
                        else if (fire)
                        begin
                            // Shift now; the dropped oldest entry seeds the sum.
                            // The new head is zero or nonpositive, so the ring
                            // scan that follows adds exactly the other entries.
                            for (int i = 1; i < HISTORY_DEPTH; i++)
                                hist_reg[i] <= hist_reg[i-1];
                            if (head_pos)
                                hist_reg[0] <= '0;
                            sum_reg <= oldest_pos ? SUM_W'(oldest[LEVEL_W-1:0]) : '0;
                            cnt_reg <= oldest_pos ? CNT_W'(1) : '0;
                        end
                        seq_reg <= fire ? SEQ_SUM : SEQ_OUT;
                        idx_reg <= '0;
                    end
                end
                SEQ_SUM:
                begin
                    // Rotate the ring once around, adding the positive tap
                    for (int i = 1; i < HISTORY_DEPTH; i++)
                        hist_reg[i] <= hist_reg[i-1];
                    hist_reg[0] <= tap;
                    if (tap_pos)
                    begin
                        sum_reg <= sum_reg + SUM_W'(tap[LEVEL_W-1:0]);
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (idx_reg == IDX_W'(HISTORY_DEPTH - 1))
                    begin
                        seq_reg   <= SEQ_DIV;
                        rem_reg   <= '0;
                        dstep_reg <= '0;
                    end
                end
                SEQ_DIV:
                begin
                    sum_reg   <= quo_next;
                    rem_reg   <= qbit ? CNT_W'(trial - {1'b0, cnt_reg}) : trial[CNT_W-1:0];
                    dstep_reg <= dstep_reg + DSTEP_W'(1);
                    if (dstep_reg == DSTEP_W'(SUM_W - 1))
                    begin
                        avg_reg <= (cnt_reg != '0) ? quo_next[LEVEL_W-1:0] : '0;
                        seq_reg <= SEQ_OUT;
                    end
                end
                SEQ_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        seq_reg       <= SEQ_IDLE;
                    end
                end
                default:
                    seq_reg <= SEQ_IDLE;
            endcase
        end
    end

    // Result payload: staged at acceptance, average patched after the divide
    always_ff @(posedge clk)
    begin
        if (seq_reg == SEQ_IDLE && accept)
        begin
            pend_reg.auto_on          <= auto_next;
            pend_reg.fan_state        <= state_next;
            pend_reg.relay_on         <= fan_running(state_next);
            pend_reg.relay_changed    <= changed;
            pend_reg.state_report     <= report;
            pend_reg.humidity_request <= request;
            pend_reg.normal_level     <= base_next;
            pend_reg.average_level    <= avg_next;
            pend_reg.time_left        <= time_left;
        end
        else if (seq_reg == SEQ_DIV && dstep_reg == DSTEP_W'(SUM_W - 1))
            pend_reg.average_level <= (cnt_reg != '0) ? quo_next[LEVEL_W-1:0] : '0;

        if (seq_reg == SEQ_OUT && out_free)
            out_reg <= pend_reg;
    end

    assign result_out.valid            = out_valid_reg;
    assign result_out.auto_on          = out_reg.auto_on;
    assign result_out.fan_state        = out_reg.fan_state;
    assign result_out.relay_on         = out_reg.relay_on;
    assign result_out.relay_changed    = out_reg.relay_changed;
    assign result_out.state_report     = out_reg.state_report;
    assign result_out.humidity_request = out_reg.humidity_request;
    assign result_out.normal_level     = out_reg.normal_level;
    assign result_out.average_level    = out_reg.average_level;
    assign result_out.time_left        = out_reg.time_left;

`ifndef ASSERT_OFF
    relay_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.relay_on == fan_running(out_reg.fan_state)))
        else $error("relay level disagrees with reported fan state");

    relay_change_reported: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.relay_changed) |-> out_reg.state_report)
        else $error("relay change without state report");

    scan_starts_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == SEQ_SUM && $past(seq_reg) == SEQ_IDLE)
            |-> ($past(item_in.mode) == MODE_TICK && $past(auto_reg)))
        else $error("history scan started by an item other than an auto tick");

    result_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == SEQ_OUT && out_free) |=> (out_valid_reg && seq_reg == SEQ_IDLE))
        else $error("staged result not moved to the output register");
`endif

endmodule
